// ===== rtl/pse_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes of the pushdata signature extractor.
package pse_pkg;

    // Width of the length field of the widest push instruction.
    localparam int LEN_FIELD_BITS = 32;

    // Configuration register indexes.
    localparam logic [1:0] CFG_OP_LEN8   = 2'd0;
    localparam logic [1:0] CFG_OP_LEN16  = 2'd1;
    localparam logic [1:0] CFG_OP_LEN32  = 2'd2;
    localparam logic [1:0] CFG_SIG_BYTES = 2'd3;

    // Summary status codes.
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_TRUNC_LEN = 2'd1;
    localparam logic [1:0] STATUS_PAST_END  = 2'd2;

    // Result kinds.
    localparam logic KIND_SIG_BYTE = 1'b0;
    localparam logic KIND_SUMMARY  = 1'b1;

    // One queued job: at most one signature byte and one summary.
    typedef struct packed {
        logic        has_sig;
        logic [7:0]  sig_byte;
        logic [15:0] sig_index;
        logic        sig_last;
        logic        has_sum;
        logic [1:0]  status;
        logic [15:0] sig_count;
    } pse_entry_t;

endpackage

// ===== rtl/pushdata_signature_extractor_top.sv =====
`timescale 1ns / 1ps
// A script byte's job passes through the job queue and then the output register before it is presented.
// Throughput: one script byte per clock while the queue has room; a final byte that also
// carries a signature byte yields two results, which leave the single output register in turn.
// The job queue of QUEUE_DEPTH entries absorbs output stalls before input backs up.
// Reset (rst_n, asynchronous, active low) restores the default opcodes and signature
// size, empties the queue and returns the parser to expecting an opcode.
module pushdata_signature_extractor_top
    import pse_pkg::*;
#(
    parameter int LENGTH_BITS = 32,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,

    input  logic        script_valid,
    output logic        script_ready,
    input  logic [7:0]  script_byte,
    input  logic        end_of_script,

    output logic        result_valid,
    input  logic        result_ready,
    output logic        kind,
    output logic [7:0]  sig_byte,
    output logic [15:0] sig_index,
    output logic        sig_last,
    output logic [1:0]  status,
    output logic [15:0] sig_count,
    output logic        last
);

    // The front end parses every accepted byte in the cycle it arrives and files any
    // results it causes as one job in the queue.  The back end drains the queue into
    // the output register, splitting a job into a signature byte and a summary when
    // the final byte of a script also carries a signature byte.

    logic       accept;
    logic       push;
    logic       pop;
    logic       q_empty;
    logic       q_full;
    pse_entry_t push_entry;
    pse_entry_t head;

    // The user must issue configuration writes only while the block is idle; the block
    // itself does not enforce this, and always takes the writes at once.
    assign cfg_ready    = 1'b1;
    // A request is refused only when the queue has no room for the job it might make.
    assign script_ready = !q_full;
    assign accept       = script_valid && script_ready;

    pse_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .accept        (accept),
        .script_byte   (script_byte),
        .end_of_script (end_of_script),
        .push          (push),
        .push_entry    (push_entry)
    );

    pse_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .empty      (q_empty),
        .full       (q_full)
    );

    pse_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .q_empty      (q_empty),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .kind         (kind),
        .sig_byte     (sig_byte),
        .sig_index    (sig_index),
        .sig_last     (sig_last),
        .status       (status),
        .sig_count    (sig_count),
        .last         (last)
    );

`ifndef NO_ASSERTIONS
    // A summary always closes the results of its byte.
    a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (kind == KIND_SUMMARY) |-> last)
        else $error("summary result without last mark");

    // Signature byte results carry neither a status nor a count.
    a_sig_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (kind == KIND_SIG_BYTE) |-> (status == STATUS_OK) && (sig_count == 16'd0))
        else $error("signature byte result with summary fields set");

    // The final byte of a script always leaves a job in the queue.
    a_eos_queued: assert property (@(posedge clk) disable iff (!rst_n)
        accept && end_of_script |=> !q_empty)
        else $error("final script byte produced no queued job");

    // The input side is held off whenever the queue is full.
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !script_ready)
        else $error("script byte accepted while the queue is full");
`endif

endmodule

// ===== rtl/pse_front.sv =====
`timescale 1ns / 1ps
// Parser front end: configuration registers and the byte-level push parser.
module pse_front
    import pse_pkg::*;
#(
    parameter int LENGTH_BITS = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    input  logic [1:0]       cfg_index,
    input  logic [7:0]       cfg_data,
    input  logic             accept,
    input  logic [7:0]       script_byte,
    input  logic             end_of_script,
    output logic             push,
    output pse_entry_t       push_entry
);

    localparam logic [1:0] PH_OPCODE  = 2'd0;
    localparam logic [1:0] PH_LENGTH  = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;
    localparam logic [1:0] PH_STOPPED = 2'd3;

    logic [7:0] op_len8_reg;
    logic [7:0] op_len16_reg;
    logic [7:0] op_len32_reg;
    logic [7:0] sig_bytes_reg;

    logic [1:0]                  phase_reg,     phase_next;
    logic [2:0]                  left_reg,      left_next;
    logic [1:0]                  shift_reg,     shift_next;
    logic [LEN_FIELD_BITS-1:0]   acc_reg,       acc_next;
    logic [LENGTH_BITS-1:0]      pay_reg,       pay_next;
    logic                        capture_reg,   capture_next;
    logic [15:0]                 total_reg,     total_next;

    logic [LEN_FIELD_BITS-1:0]   len_value;
    logic [LENGTH_BITS-1:0]      len_sat;
    pse_entry_t                  entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_len8_reg   <= 8'd12;
            op_len16_reg  <= 8'd13;
            op_len32_reg  <= 8'd14;
            sig_bytes_reg <= 8'd64;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_OP_LEN8:   op_len8_reg   <= cfg_data;
                CFG_OP_LEN16:  op_len16_reg  <= cfg_data;
                CFG_OP_LEN32:  op_len32_reg  <= cfg_data;
                CFG_SIG_BYTES: sig_bytes_reg <= cfg_data;
                default:       op_len8_reg   <= op_len8_reg;
            endcase
        end
    end

    // Length assembled so far plus this byte, and its value clamped to the counter width.
    assign len_value = acc_reg | (LEN_FIELD_BITS'(script_byte) << {shift_reg, 3'b000});
    assign len_sat   = ((len_value >> LENGTH_BITS) != '0) ? '1
                                                          : len_value[LENGTH_BITS-1:0];

    always_comb
    begin
        phase_next   = phase_reg;
        left_next    = left_reg;
        shift_next   = shift_reg;
        acc_next     = acc_reg;
        pay_next     = pay_reg;
        capture_next = capture_reg;
        total_next   = total_reg;
        entry        = '0;

        unique case (phase_reg)
            PH_OPCODE:
            begin
                shift_next = 2'd0;
                acc_next   = '0;
                pay_next   = '0;
                phase_next = PH_LENGTH;
                if (script_byte == op_len8_reg)
                    left_next = 3'd1;
                else if (script_byte == op_len16_reg)
                    left_next = 3'd2;
                else if (script_byte == op_len32_reg)
                    left_next = 3'd4;
                else
                begin
                    left_next  = 3'd0;
                    phase_next = PH_STOPPED;
                    shift_next = shift_reg;
                    acc_next   = acc_reg;
                    pay_next   = pay_reg;
                end
            end
            PH_LENGTH:
            begin
                acc_next   = len_value;
                shift_next = shift_reg + 2'd1;
                left_next  = (left_reg != 3'd0) ? left_reg - 3'd1 : 3'd0;
                if (left_reg <= 3'd1)
                begin
                    capture_next = (sig_bytes_reg != 8'd0)
                                && (len_value == LEN_FIELD_BITS'(sig_bytes_reg));
                    pay_next     = len_sat;
                    phase_next   = (len_sat == '0) ? PH_OPCODE : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                if (capture_reg)
                begin
                    entry.has_sig   = 1'b1;
                    entry.sig_byte  = script_byte;
                    entry.sig_index = total_reg;
                    entry.sig_last  = (pay_reg == LENGTH_BITS'(1));
                end
                pay_next = (pay_reg != '0) ? pay_reg - LENGTH_BITS'(1) : '0;
                if (pay_reg <= LENGTH_BITS'(1))
                begin
                    if (capture_reg && (total_reg != 16'hFFFF))
                        total_next = total_reg + 16'd1;
                    capture_next = 1'b0;
                    phase_next   = PH_OPCODE;
                end
            end
            PH_STOPPED:
            begin
                phase_next = PH_STOPPED;
            end
            default:
            begin
                phase_next = PH_STOPPED;
            end
        endcase

        // The final byte reports where parsing stood and starts afresh for the next script.
        if (end_of_script)
        begin
            entry.has_sum = 1'b1;
            if (phase_next == PH_LENGTH)
                entry.status = STATUS_TRUNC_LEN;
            else if (phase_next == PH_PAYLOAD)
                entry.status = STATUS_PAST_END;
            else
                entry.status = STATUS_OK;
            entry.sig_count = (entry.status == STATUS_OK) ? total_next : 16'd0;

            phase_next   = PH_OPCODE;
            left_next    = 3'd0;
            shift_next   = 2'd0;
            acc_next     = '0;
            pay_next     = '0;
            capture_next = 1'b0;
            total_next   = 16'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_OPCODE;
            left_reg    <= 3'd0;
            shift_reg   <= 2'd0;
            acc_reg     <= '0;
            pay_reg     <= '0;
            capture_reg <= 1'b0;
            total_reg   <= 16'd0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            left_reg    <= left_next;
            shift_reg   <= shift_next;
            acc_reg     <= acc_next;
            pay_reg     <= pay_next;
            capture_reg <= capture_next;
            total_reg   <= total_next;
        end
    end

    assign push       = accept && (entry.has_sig || entry.has_sum);
    assign push_entry = entry;

endmodule

// ===== rtl/pse_fifo.sv =====
`timescale 1ns / 1ps
// Short job queue between the parser and the result sequencer.
module pse_fifo
    import pse_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  pse_entry_t push_entry,
    input  logic       pop,
    output pse_entry_t head,
    output logic       empty,
    output logic       full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pse_entry_t         store [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg,  count_next;
    logic               do_push, do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = store[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            store[wr_ptr_reg] <= push_entry;
    end

endmodule

// ===== rtl/pse_back.sv =====
`timescale 1ns / 1ps
// Result sequencer: turns queued jobs into results and holds the output register.
module pse_back
    import pse_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  pse_entry_t  head,
    input  logic        q_empty,
    output logic        pop,
    output logic        result_valid,
    input  logic        result_ready,
    output logic        kind,
    output logic [7:0]  sig_byte,
    output logic [15:0] sig_index,
    output logic        sig_last,
    output logic [1:0]  status,
    output logic [15:0] sig_count,
    output logic        last
);

    logic        valid_reg,     valid_next;
    logic        sum_phase_reg, sum_phase_next;
    logic        load, take;
    logic        kind_next;
    logic [7:0]  byte_next;
    logic [15:0] index_next;
    logic        sig_last_next;
    logic [1:0]  status_next;
    logic [15:0] count_next;
    logic        last_next;

    logic        kind_reg;
    logic [7:0]  byte_reg;
    logic [15:0] index_reg;
    logic        sig_last_reg;
    logic [1:0]  status_reg;
    logic [15:0] count_reg;
    logic        last_reg;

    assign load = !valid_reg || result_ready;
    assign take = load && !q_empty;

    always_comb
    begin
        valid_next     = valid_reg;
        sum_phase_next = sum_phase_reg;
        pop            = 1'b0;
        kind_next      = KIND_SUMMARY;
        byte_next      = 8'd0;
        index_next     = 16'd0;
        sig_last_next  = 1'b0;
        status_next    = head.status;
        count_next     = head.sig_count;
        last_next      = 1'b1;

        if (load)
            valid_next = !q_empty;

        if (head.has_sig && !sum_phase_reg)
        begin
            kind_next     = KIND_SIG_BYTE;
            byte_next     = head.sig_byte;
            index_next    = head.sig_index;
            sig_last_next = head.sig_last;
            status_next   = STATUS_OK;
            count_next    = 16'd0;
            last_next     = !head.has_sum;
            if (take)
            begin
                if (head.has_sum)
                    sum_phase_next = 1'b1;
                else
                    pop = 1'b1;
            end
        end
        else if (take)
        begin
            pop            = 1'b1;
            sum_phase_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            sum_phase_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            sum_phase_reg <= sum_phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            kind_reg     <= kind_next;
            byte_reg     <= byte_next;
            index_reg    <= index_next;
            sig_last_reg <= sig_last_next;
            status_reg   <= status_next;
            count_reg    <= count_next;
            last_reg     <= last_next;
        end
    end

    assign result_valid = valid_reg;
    assign kind         = kind_reg;
    assign sig_byte     = byte_reg;
    assign sig_index    = index_reg;
    assign sig_last     = sig_last_reg;
    assign status       = status_reg;
    assign sig_count    = count_reg;
    assign last         = last_reg;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the pushdata signature extractor with its own parser model.
module tb;
    import pse_pkg::*;

    // Timing of the bench. The clock period is 4 ns.
    localparam int CLK_HALF_NS = 2;
    localparam int RESET_CYCLES = 6;
    // The block passes each result through a job queue of four jobs and an output register.
    // Before any register write we therefore wait until it has drained and settled.
    localparam int SETTLE_CYCLES = 8;
    localparam int IDLE_PERCENT = 16;
    localparam int HOLD_OFF_CYCLES = 150;
    localparam int RANDOM_BYTES = 800;
    localparam int RANDOM_PHASES = 6;
    // Time limit of the whole run in ns.
    localparam int TIMEOUT_NS = 200_000;

    // Where the parser stands between two script bytes.
    typedef enum logic [1:0] {
        EXPECT_OPCODE,
        READ_LENGTH,
        SKIP_PAYLOAD,
        STOPPED
    } parse_phase_t;

    // One result as the block should present it.
    typedef struct packed {
        logic        kind;
        logic [7:0]  sig_byte;
        logic [15:0] sig_index;
        logic        sig_last;
        logic [1:0]  status;
        logic [15:0] sig_count;
        logic        last;
    } extract_result_t;

    logic        clk;
    logic        rst_n = 1'b0;

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_OP_LEN8;
    logic [7:0]  cfg_data = 8'd0;

    logic        script_valid = 1'b0;
    logic        script_ready;
    logic [7:0]  script_byte = 8'd0;
    logic        end_of_script = 1'b0;

    logic        result_valid;
    logic        result_ready = 1'b0;
    logic        kind;
    logic [7:0]  sig_byte;
    logic [15:0] sig_index;
    logic        sig_last;
    logic [1:0]  status;
    logic [15:0] sig_count;
    logic        last;

    // Register copies held by the parser model. They start at the reset values.
    logic [7:0]  op_len8 = 8'd12;
    logic [7:0]  op_len16 = 8'd13;
    logic [7:0]  op_len32 = 8'd14;
    logic [7:0]  sig_len = 8'd64;

    // Parser state of the model.
    parse_phase_t phase = EXPECT_OPCODE;
    logic [2:0]  length_left = 3'd0;
    logic [1:0]  length_shift = 2'd0;
    logic [31:0] payload_left = 32'd0;
    logic        capturing = 1'b0;
    logic [15:0] sig_total = 16'd0;

    // Results that the block still owes us, oldest first.
    extract_result_t pending_results[$];

    int          mismatches = 0;
    int          bytes_accepted = 0;
    // Idling switches for each side, and a hold-off request for the receiver.
    bit          tx_idle_on = 1'b1;
    bit          rx_idle_on = 1'b1;
    int          hold_request = 0;
    int          hold_left = 0;

    pushdata_signature_extractor_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .script_valid  (script_valid),
        .script_ready  (script_ready),
        .script_byte   (script_byte),
        .end_of_script (end_of_script),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .kind          (kind),
        .sig_byte      (sig_byte),
        .sig_index     (sig_index),
        .sig_last      (sig_last),
        .status        (status),
        .sig_count     (sig_count),
        .last          (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_HALF_NS) clk = ~clk;
    end

    // The parser model. It takes one accepted script byte and queues whatever results that
    // byte should cause: at most a signature byte and a summary.
    function automatic void parse_script_byte(input logic [7:0] b, input logic eos);
        extract_result_t r;
        logic [1:0] st;
        int caused;
        caused = 0;
        case (phase)
            EXPECT_OPCODE:
            begin
                // The one-byte push wins when opcodes are equal, then the two-byte push.
                if (b == op_len8)
                    length_left = 3'd1;
                else if (b == op_len16)
                    length_left = 3'd2;
                else if (b == op_len32)
                    length_left = 3'd4;
                else
                    length_left = 3'd0;
                if (length_left != 3'd0)
                begin
                    phase = READ_LENGTH;
                    length_shift = 2'd0;
                    payload_left = 32'd0;
                end
                else
                    phase = STOPPED;
            end
            READ_LENGTH:
            begin
                // Little-endian length. The match against the signature size uses all of
                // the length, so a length of 0x140 is no 64-byte signature.
                payload_left = payload_left | (32'(b) << (8 * int'(length_shift)));
                length_shift = length_shift + 2'd1;
                if (length_left != 3'd0)
                    length_left = length_left - 3'd1;
                if (length_left == 3'd0)
                begin
                    capturing = (sig_len != 8'd0) && (payload_left == 32'(sig_len));
                    phase = (payload_left == 32'd0) ? EXPECT_OPCODE : SKIP_PAYLOAD;
                end
            end
            SKIP_PAYLOAD:
            begin
                if (capturing)
                begin
                    r = '0;
                    r.kind = KIND_SIG_BYTE;
                    r.sig_byte = b;
                    r.sig_index = sig_total;
                    r.sig_last = (payload_left == 32'd1);
                    pending_results.push_back(r);
                    caused++;
                end
                if (payload_left != 32'd0)
                    payload_left = payload_left - 32'd1;
                if (payload_left == 32'd0)
                begin
                    // The count sticks at its top value, and so does the index.
                    if (capturing && sig_total != 16'hFFFF)
                        sig_total = sig_total + 16'd1;
                    capturing = 1'b0;
                    phase = EXPECT_OPCODE;
                end
            end
            default:
            begin
                // After a stop every byte is ignored until the final one.
            end
        endcase

        if (eos)
        begin
            case (phase)
                READ_LENGTH:  st = STATUS_TRUNC_LEN;
                SKIP_PAYLOAD: st = STATUS_PAST_END;
                default:      st = STATUS_OK;
            endcase
            r = '0;
            r.kind = KIND_SUMMARY;
            r.status = st;
            // A broken script reports no signatures at all.
            r.sig_count = (st == STATUS_OK) ? sig_total : 16'd0;
            pending_results.push_back(r);
            caused++;
            phase = EXPECT_OPCODE;
            length_left = 3'd0;
            length_shift = 2'd0;
            payload_left = 32'd0;
            capturing = 1'b0;
            sig_total = 16'd0;
        end

        if (caused > 0)
            pending_results[pending_results.size() - 1].last = 1'b1;
    endfunction

    // Receiver side. A hold-off request keeps ready low until its count has run down; otherwise
    // ready drops at random in about 16 percent of clocks while idling is on.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_request != 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0)
            begin
                result_ready <= 1'b0;
                hold_left--;
            end
            else
                result_ready <= !(rx_idle_on && $urandom_range(99) < IDLE_PERCENT);
        end
    end

    task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    // Every accepted result is compared field by field with the oldest expected one.
    always @(posedge clk)
    begin
        extract_result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                $display("%0t ns: result expected none, got kind %0d byte %0h status %0d",
                         $time, kind, sig_byte, status);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("kind", 16'(want.kind), 16'(kind));
                check_field("sig_byte", 16'(want.sig_byte), 16'(sig_byte));
                check_field("sig_index", want.sig_index, sig_index);
                check_field("sig_last", 16'(want.sig_last), 16'(sig_last));
                check_field("status", 16'(want.status), 16'(status));
                check_field("sig_count", want.sig_count, sig_count);
                check_field("last", 16'(want.last), 16'(last));
            end
        end
    end

    // Sends one script byte request. It is entered at a falling edge and returns at the
    // falling edge after acceptance with valid still high, so that a following request
    // can follow straight on without valid dropping.
    task automatic send_byte(input logic [7:0] b, input logic eos);
        while (tx_idle_on && $urandom_range(99) < IDLE_PERCENT)
        begin
            script_valid <= 1'b0;
            @(negedge clk);
        end
        script_byte <= b;
        end_of_script <= eos;
        script_valid <= 1'b1;
        @(posedge clk);
        while (!script_ready)
            @(posedge clk);
        parse_script_byte(b, eos);
        bytes_accepted++;
        @(negedge clk);
    endtask

    // Sends a whole script, marking its final byte.
    task automatic send_script(input logic [7:0] s[$]);
        foreach (s[i])
            send_byte(s[i], i == s.size() - 1);
    endtask

    // Stops sending and waits until every expected result has come, then a little longer
    // in case the block is still busy with a byte that causes nothing.
    task automatic wait_drain();
        script_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [7:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_OP_LEN8:   op_len8 = val;
            CFG_OP_LEN16:  op_len16 = val;
            CFG_OP_LEN32:  op_len32 = val;
            CFG_SIG_BYTES: sig_len = val;
            default:       ;
        endcase
        @(negedge clk);
    endtask

    // Writes all four registers back to back once the block has gone quiet.
    task automatic set_config(input logic [7:0] op8, input logic [7:0] op16,
                              input logic [7:0] op32, input logic [7:0] size);
        wait_drain();
        write_register(CFG_OP_LEN8, op8);
        write_register(CFG_OP_LEN16, op16);
        write_register(CFG_OP_LEN32, op32);
        write_register(CFG_SIG_BYTES, size);
        cfg_valid <= 1'b0;
    endtask

    // Builds and sends one random script. Most are runs of well-formed pushes, about half
    // of them signatures; the rest end in a stop opcode, are cut short, or are noise.
    // With large signatures a script carries a single push to keep the byte count in check.
    task automatic send_random_script();
        logic [7:0]  s[$];
        logic [7:0]  opc;
        logic [31:0] len;
        int sel;
        int ending;
        int cut;
        int pushes;
        pushes = (sig_len > 8'd64) ? 1 : $urandom_range(1, 4);
        for (int p = 0; p < pushes; p++)
        begin
            sel = $urandom_range(2);
            if ($urandom_range(99) < 55)
                len = 32'(sig_len);
            else
                len = $urandom_range(0, 6);
            // Now and then a random length; above 256 only six payload bytes follow, leaving it unfinished.
            if ($urandom_range(99) < 8)
                len = $urandom;
            case (sel)
                0:
                begin
                    len = len & 32'hFF;
                    s.push_back(op_len8);
                    s.push_back(len[7:0]);
                end
                1:
                begin
                    len = len & 32'hFFFF;
                    s.push_back(op_len16);
                    s.push_back(len[7:0]);
                    s.push_back(len[15:8]);
                end
                default:
                begin
                    s.push_back(op_len32);
                    for (int k = 0; k < 4; k++)
                        s.push_back(len[8 * k +: 8]);
                end
            endcase
            if (len > 32'd256)
                len = 32'd6;
            for (int k = 0; k < int'(len); k++)
                s.push_back(8'($urandom_range(255)));
        end

        ending = $urandom_range(99);
        if (ending < 15)
        begin
            // Stop opcode followed by bytes that must be ignored.
            do
                opc = 8'($urandom_range(255));
            while (opc == op_len8 || opc == op_len16 || opc == op_len32);
            s.push_back(opc);
            repeat ($urandom_range(0, 3)) s.push_back(8'($urandom_range(255)));
        end
        else if (ending < 27)
        begin
            cut = $urandom_range(1, s.size());
            while (s.size() > cut)
                void'(s.pop_back());
        end
        else if (ending < 35)
        begin
            s.delete();
            repeat ($urandom_range(1, 6)) s.push_back(8'($urandom_range(255)));
        end
        send_script(s);
    endtask

    // Reset values of the registers: a zero-length push, a short non-signature push, then a
    // stop opcode after which even a valid push opcode is ignored.
    task automatic test_default_registers();
        send_script('{8'd12, 8'd0, 8'd13, 8'd1, 8'd0, 8'hAA, 8'h99, 8'd12});
    endtask

    // One signature through each push kind, with opcodes at the extremes and the smallest
    // signature size. The last signature byte is also the final byte, so it yields two results.
    task automatic test_push_kinds();
        set_config(8'd0, 8'd255, 8'd128, 8'd1);
        send_script('{8'd0, 8'd1, 8'h00,
                      8'd255, 8'd1, 8'd0, 8'hFF,
                      8'd128, 8'd1, 8'd0, 8'd0, 8'd0, 8'h5A});
    endtask

    // Scripts that end inside a payload or inside a length field, and a length that
    // matches the signature size only in its low byte.
    task automatic test_broken_scripts();
        send_script('{8'd0, 8'd3, 8'h81});
        send_script('{8'd128, 8'd1, 8'd0});
        send_script('{8'd255});
        send_script('{8'd255, 8'd1, 8'd1, 8'h07});
    endtask

    // With all three opcodes equal the one-byte push must win.
    task automatic test_equal_opcodes();
        set_config(8'h40, 8'h40, 8'h40, 8'd1);
        send_script('{8'h40, 8'd1, 8'hC3, 8'h40, 8'd0, 8'h41});
    endtask

    // The receiver holds off for a long stretch while two 40-byte signatures are offered,
    // so the job queue fills and the script input must stall.
    task automatic test_output_hold_off();
        set_config(8'd12, 8'd13, 8'd14, 8'd40);
        hold_request = HOLD_OFF_CYCLES;
        repeat (2)
        begin
            send_byte(8'd12, 1'b0);
            send_byte(8'd40, 1'b0);
            repeat (40) send_byte(8'($urandom_range(255)), 1'b0);
        end
        send_byte(8'h99, 1'b1);
    endtask

    // Random scripts under several settings. The first phase runs with no idling on
    // either side; the others idle at random. The extremes of the signature size are in.
    task automatic test_random_scripts();
        int start;
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0: set_config(8'd12, 8'd13, 8'd14, 8'd3);
                1: set_config(8'd0, 8'd255, 8'd1, 8'd1);
                2: set_config(8'($urandom_range(255)), 8'($urandom_range(255)),
                              8'($urandom_range(255)), 8'd255);
                default: set_config(8'($urandom_range(255)), 8'($urandom_range(255)),
                                    8'($urandom_range(255)), 8'($urandom_range(2, 8)));
            endcase
            tx_idle_on = (ph != 0);
            rx_idle_on = (ph != 0);
            start = bytes_accepted;
            while (bytes_accepted - start < RANDOM_BYTES / RANDOM_PHASES)
                send_random_script();
        end
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_default_registers();
        test_push_kinds();
        test_broken_scripts();
        test_equal_opcodes();
        test_output_hold_off();
        test_random_scripts();

        wait_drain();
        if (mismatches == 0)
            $display("pushdata_signature_extractor_top regression: pass");
        else
            $display("pushdata_signature_extractor_top regression: fail");
        $finish;
    end

    // A hung handshake ends the run here.
    initial
    begin
        #(TIMEOUT_NS);
        $display("pushdata_signature_extractor_top regression: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/pse_pkg.sv
rtl/pse_front.sv
rtl/pse_fifo.sv
rtl/pse_back.sv
rtl/pushdata_signature_extractor_top.sv
dv/tb.sv
